@@ src/gray_histogram_with_mode_unit_assert.svh @@
// Assertion macros for the gray histogram unit checker.
// Used by ghm_checker; depends on the i_clk and i_rst_n port names.
`ifndef GRAY_HISTOGRAM_WITH_MODE_UNIT_ASSERT_SVH
`define GRAY_HISTOGRAM_WITH_MODE_UNIT_ASSERT_SVH

// Checked on every rising clock edge outside of reset.
`define GHM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GHM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/ghm_pkg.sv @@
// Shared types and constants for the gray histogram unit.
// Used by ghm_ctrl, ghm_datapath and gray_histogram_with_mode_unit.
package ghm_pkg;

    localparam logic [1:0] CMD_COUNT = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam int CMD_W       = 2;
    localparam int PIXEL_W     = 8;
    localparam int OUT_COUNT_W = 24;
    localparam int MODE_BIN_W  = 8;
    localparam int LEVEL_W     = 16;

    // 65535 / 255 is exactly 257, so the scaling needs no rounding.
    localparam logic [LEVEL_W-1:0] LEVEL_SCALE = LEVEL_W'(65535 / 255);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic rd_en;
        logic commit;
        logic sweep_en;
    } t_ctl;

    typedef struct packed {
        logic is_clear;
        logic sweep_last;
        logic out_ready;
    } t_sts;

endpackage

@@ src/gray_histogram_with_mode_unit.sv @@
// Gray histogram unit with mode tracking: a new transaction waits until the last one is done.
// A result is registered after its transaction is latched and its bin is read, and later work waits
// while the output register is stalled; the bin memory's single read port sets this pace.
// Reset and a clear command both run a clearing pass over all NUM_BINS bins of the bin
// memory, during which no transaction is accepted. Synchronous active-low reset.
module gray_histogram_with_mode_unit #(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ghm_pkg::CMD_W-1:0]           i_cmd,
    input  logic [ghm_pkg::PIXEL_W-1:0]         i_pixel_value,
    input  logic [ghm_pkg::PIXEL_W-1:0]         i_bin_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ghm_pkg::OUT_COUNT_W-1:0]     o_bin_count,
    output logic [ghm_pkg::OUT_COUNT_W-1:0]     o_mode_count,
    output logic [ghm_pkg::MODE_BIN_W-1:0]      o_mode_bin,
    output logic [ghm_pkg::LEVEL_W-1:0]         o_mode_level16
);

    ghm_pkg::t_ctl w_ctl;
    ghm_pkg::t_sts w_sts;

    ghm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    ghm_datapath #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .i_cmd          (i_cmd),
        .i_pixel_value  (i_pixel_value),
        .i_bin_index    (i_bin_index),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_bin_count    (o_bin_count),
        .o_mode_count   (o_mode_count),
        .o_mode_bin     (o_mode_bin),
        .o_mode_level16 (o_mode_level16)
    );

endmodule

@@ src/ghm_ctrl.sv @@
// Controller state machine for the gray histogram unit.
// Depends on ghm_pkg for the state type and the command and status structs.
module ghm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ghm_pkg::t_sts i_sts,
    output ghm_pkg::t_ctl o_ctl
);

    ghm_pkg::t_state r_state;
    ghm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ghm_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_ctl          = '0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            ghm_pkg::ST_CLEAR: begin
                o_ctl.sweep_en = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ghm_pkg::ST_IDLE;
                end
            end
            ghm_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = ghm_pkg::ST_READ;
                end
            end
            ghm_pkg::ST_READ: begin
                o_ctl.rd_en = 1'b1;
                n_state     = ghm_pkg::ST_UPDATE;
            end
            ghm_pkg::ST_UPDATE: begin
                if (i_sts.out_ready) begin
                    o_ctl.commit = 1'b1;
                    n_state      = i_sts.is_clear ? ghm_pkg::ST_CLEAR : ghm_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

@@ src/ghm_datapath.sv @@
// Datapath of the gray histogram unit: bin memory, mode tracker and output register.
// Depends on ghm_pkg; driven by the command struct from ghm_ctrl.
module ghm_datapath #(
    parameter int NUM_BINS   = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ghm_pkg::t_ctl                       i_ctl,
    output ghm_pkg::t_sts                       o_sts,
    input  logic [ghm_pkg::CMD_W-1:0]           i_cmd,
    input  logic [ghm_pkg::PIXEL_W-1:0]         i_pixel_value,
    input  logic [ghm_pkg::PIXEL_W-1:0]         i_bin_index,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [ghm_pkg::OUT_COUNT_W-1:0]     o_bin_count,
    output logic [ghm_pkg::OUT_COUNT_W-1:0]     o_mode_count,
    output logic [ghm_pkg::MODE_BIN_W-1:0]      o_mode_bin,
    output logic [ghm_pkg::LEVEL_W-1:0]         o_mode_level16
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    logic [COUNT_BITS-1:0]            r_bins [NUM_BINS];
    logic [ghm_pkg::CMD_W-1:0]        r_cmd;
    logic [BIN_W-1:0]                 r_addr;
    logic                             r_rd_ok;
    logic [COUNT_BITS-1:0]            r_rdata;
    logic [BIN_W-1:0]                 r_sweep;
    logic [COUNT_BITS-1:0]            r_peak_count;
    logic [BIN_W-1:0]                 r_peak_bin;
    logic                             r_out_valid;
    logic [ghm_pkg::OUT_COUNT_W-1:0]  r_bin_count;
    logic [ghm_pkg::OUT_COUNT_W-1:0]  r_mode_count;
    logic [ghm_pkg::MODE_BIN_W-1:0]   r_mode_bin;
    logic [ghm_pkg::LEVEL_W-1:0]      r_mode_level;

    logic [COUNT_BITS-1:0]            n_peak_count;
    logic [BIN_W-1:0]                 n_peak_bin;
    logic [BIN_W-1:0]                 w_in_addr;
    logic                             w_in_rd_ok;
    logic [COUNT_BITS-1:0]            w_new;
    logic [COUNT_BITS-1:0]            w_result;
    logic                             w_we;
    logic [BIN_W-1:0]                 w_waddr;
    logic [COUNT_BITS-1:0]            w_wdata;
    logic [ghm_pkg::MODE_BIN_W-1:0]   w_mode_bin;

    always_comb begin
        w_in_rd_ok = 32'(i_bin_index) < 32'(NUM_BINS);
        if (i_cmd == ghm_pkg::CMD_COUNT) begin
            if (32'(i_pixel_value) > 32'(NUM_BINS - 1)) begin
                w_in_addr = LAST_BIN;
            end else begin
                w_in_addr = BIN_W'(i_pixel_value);
            end
        end else if (w_in_rd_ok) begin
            w_in_addr = BIN_W'(i_bin_index);
        end else begin
            w_in_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd   <= i_cmd;
            r_addr  <= w_in_addr;
            r_rd_ok <= w_in_rd_ok;
        end
    end

    // A saturated bin keeps its count.
    assign w_new = (&r_rdata) ? r_rdata : r_rdata + COUNT_BITS'(1);

    always_comb begin
        n_peak_count = r_peak_count;
        n_peak_bin   = r_peak_bin;
        w_result     = '0;
        unique case (r_cmd)
            ghm_pkg::CMD_COUNT: begin
                w_result = w_new;
                if (w_new > r_peak_count) begin
                    n_peak_count = w_new;
                    n_peak_bin   = r_addr;
                end
            end
            ghm_pkg::CMD_READ: begin
                if (r_rd_ok) begin
                    w_result = r_rdata;
                end
            end
            ghm_pkg::CMD_CLEAR: begin
                n_peak_count = '0;
                n_peak_bin   = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_we    = i_ctl.sweep_en || (i_ctl.commit && (r_cmd == ghm_pkg::CMD_COUNT));
    assign w_waddr = i_ctl.sweep_en ? r_sweep : r_addr;
    assign w_wdata = i_ctl.sweep_en ? '0 : w_new;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_bins[w_waddr] <= w_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_bins[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep      <= '0;
            r_peak_count <= '0;
            r_peak_bin   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.sweep_en) begin
                r_sweep <= (r_sweep == LAST_BIN) ? '0 : r_sweep + BIN_W'(1);
            end
            if (i_ctl.commit) begin
                r_peak_count <= n_peak_count;
                r_peak_bin   <= n_peak_bin;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign w_mode_bin = ghm_pkg::MODE_BIN_W'(n_peak_bin);

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_bin_count  <= ghm_pkg::OUT_COUNT_W'(w_result);
            r_mode_count <= ghm_pkg::OUT_COUNT_W'(n_peak_count);
            r_mode_bin   <= w_mode_bin;
            r_mode_level <= ghm_pkg::LEVEL_W'(w_mode_bin) * ghm_pkg::LEVEL_SCALE;
        end
    end

    assign o_sts.is_clear   = (r_cmd == ghm_pkg::CMD_CLEAR);
    assign o_sts.sweep_last = (r_sweep == LAST_BIN);
    assign o_sts.out_ready  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_bin_count    = r_bin_count;
    assign o_mode_count   = r_mode_count;
    assign o_mode_bin     = r_mode_bin;
    assign o_mode_level16 = r_mode_level;

endmodule

@@ src/ghm_checker.sv @@
// Port-level checker for the gray histogram unit, bound to the top level below.
// Depends on gray_histogram_with_mode_unit_assert.svh for the assertion macros.
`include "gray_histogram_with_mode_unit_assert.svh"

module ghm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [23:0] o_bin_count,
    input logic [23:0] o_mode_count,
    input logic [7:0]  o_mode_bin,
    input logic [15:0] o_mode_level16
);

    `GHM_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_bin_count) && $stable(o_mode_count) && $stable(o_mode_bin), "stalled result changed")
    `GHM_ASSERT(a_one_at_a_time, i_in_valid && !o_in_stall |=> o_in_stall, "second transaction accepted while busy")
    `GHM_ASSERT(a_result_source, $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 3), "result without matching transaction")
    `GHM_ASSERT(a_level_scale, o_out_valid |-> o_mode_level16 == {o_mode_bin, o_mode_bin}, "mode level does not match mode bin")
    `GHM_ASSERT_ALWAYS(a_clear_after_reset, $rose(i_rst_n) |-> o_in_stall, "transaction accepted during clearing pass")

endmodule

bind gray_histogram_with_mode_unit ghm_checker u_ghm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_bin_count    (o_bin_count),
    .o_mode_count   (o_mode_count),
    .o_mode_bin     (o_mode_bin),
    .o_mode_level16 (o_mode_level16)
);
